// ===== rtl/core/nssdp_pkg.sv =====
// Shared types and constants for the numeric string significant-digit parser.
// Used by the front classifier, the item queue, the back engine and the top level.
package nssdp_pkg;

	localparam int MAX_CHARS = 64;
	localparam int POS_W     = $clog2(MAX_CHARS + 2);
	localparam int TALLY_W   = $clog2(MAX_CHARS + 2);
	localparam int DIG_W     = 7;
	localparam int EXP_W     = 15;
	localparam int MAG_W     = 14;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_CHARS);
	localparam logic [MAG_W-1:0] EXP_SAT = MAG_W'(9999);
	localparam logic [DIG_W-1:0] DIG_SAT = DIG_W'(127);

	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_EUP   = 8'h45;
	localparam logic [7:0] CH_ELOW  = 8'h65;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef enum logic [2:0] {
		CL_NUL,
		CL_ZERO,
		CL_NZ,
		CL_POINT,
		CL_EXP,
		CL_PLUS,
		CL_MINUS,
		CL_OTHER
	} char_cls_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_EMPTY,
		ST_NONUM,
		ST_DBLPT,
		ST_BADSCI,
		ST_LONG
	} status_t;

	// One classified character as it travels from front to back.
	typedef struct packed {
		char_cls_t  cls;
		logic [3:0] dval;   // digit value for CL_ZERO / CL_NZ
		logic       proc;   // feed to the parsers
		logic       fin;    // string ends with this beat
		logic       empty;  // NUL as first character
		logic       over;   // string exceeded MAX_CHARS
	} nssdp_item_t;

endpackage

// ===== rtl/core/nssdp_front.sv =====
// Front classifier: accepts characters, tracks the string position,
// handles the leading minus and the length limit. Depends on nssdp_pkg.
module nssdp_front import nssdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [7:0]  in_char,
	input  logic        in_last,
	input  logic        q_full,
	output logic        in_ready,
	output logic        push,
	output nssdp_item_t push_item
);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_new;
	logic             is_digit;
	logic             skip;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign is_digit = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
	assign skip     = (pos_q == '0) && (in_char == CH_MINUS);
	assign pos_new  = (pos_q <= MAX_POS) ? pos_q + POS_W'(1) : pos_q;

	always_comb begin
		push_item.dval = 4'(in_char - CH_ZERO);
		if (in_char == CH_NUL)
			push_item.cls = CL_NUL;
		else if (in_char == CH_ZERO)
			push_item.cls = CL_ZERO;
		else if (is_digit)
			push_item.cls = CL_NZ;
		else if (in_char == CH_POINT)
			push_item.cls = CL_POINT;
		else if (in_char == CH_EUP || in_char == CH_ELOW)
			push_item.cls = CL_EXP;
		else if (in_char == CH_PLUS)
			push_item.cls = CL_PLUS;
		else if (in_char == CH_MINUS)
			push_item.cls = CL_MINUS;
		else
			push_item.cls = CL_OTHER;

		if (in_char == CH_NUL) begin
			push_item.proc  = 1'b0;
			push_item.fin   = 1'b1;
			push_item.empty = (pos_q == '0);
			push_item.over  = (pos_q > MAX_POS);
		end else begin
			push_item.proc  = (pos_new <= MAX_POS) && !skip;
			push_item.fin   = in_last;
			push_item.empty = 1'b0;
			push_item.over  = (pos_new > MAX_POS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= push_item.fin ? '0 : pos_new;
		end
	end

endmodule

// ===== rtl/core/nssdp_queue.sv =====
// Short queue of classified characters between front and back.
// Depends on nssdp_pkg for the item type and depth.
module nssdp_queue import nssdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  nssdp_item_t push_item,
	input  logic        pop,
	output logic        full,
	output logic        item_valid,
	output nssdp_item_t pop_item
);

	nssdp_item_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign item_valid = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> item_valid)
		else $error("pop from empty queue");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> full)
		else $error("full queue drained without pop");

endmodule

// ===== rtl/core/nssdp_back.sv =====
// Back engine: fixed-notation counter and scientific-form checker updated
// per character, result formed at string end into the output register. Depends on nssdp_pkg.
module nssdp_back import nssdp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  nssdp_item_t             item,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [DIG_W-1:0]        out_digits,
	output logic signed [EXP_W-1:0] out_exp,
	output status_t                 out_status
);

	typedef enum logic [2:0] {
		SP_LEAD,
		SP_INT,
		SP_FRAC,
		SP_ESIGN,
		SP_EDIG1,
		SP_EDIGS,
		SP_DONE
	} sci_phase_t;

	typedef enum logic [1:0] {
		FE_NONE,
		FE_NONUM,
		FE_DBLPT
	} fx_err_t;

	// fixed-notation state
	logic                      fx_digit_q, fx_point_q, fx_nz_q, fx_stop_q;
	fx_err_t                   fx_err_q;
	logic [TALLY_W-1:0]        nzt_q, pend_q, left_q;
	logic signed [TALLY_W:0]   rp_q;
	// scientific state
	sci_phase_t                phase_q;
	logic [TALLY_W-1:0]        mant_q;
	logic [MAG_W-1:0]          mag_q;
	logic                      neg_q, sci_ok_q, saw_e_q;

	logic                      n_digit, n_point, n_nz, n_stop;
	fx_err_t                   n_err;
	logic [TALLY_W-1:0]        n_nzt, n_pend, n_left;
	logic signed [TALLY_W:0]   n_rp;
	sci_phase_t                n_phase;
	logic [TALLY_W-1:0]        n_mant;
	logic [MAG_W-1:0]          n_mag;
	logic                      n_neg, n_sci_ok, n_saw_e;

	logic                      is_dec;
	logic [MAG_W+2:0]          mag_acc;
	logic [TALLY_W-1:0]        r_digits;
	logic signed [EXP_W-1:0]   r_exp;
	status_t                   r_status;
	logic                      take;

	logic                    out_valid_q;
	logic [DIG_W-1:0]        out_digits_q;
	logic signed [EXP_W-1:0] out_exp_q;
	status_t                 out_status_q;

	assign is_dec  = (item.cls == CL_ZERO) || (item.cls == CL_NZ);
	assign mag_acc = (MAG_W+3)'(mag_q) * (MAG_W+3)'(10) + (MAG_W+3)'(item.dval);
	assign take    = item_valid && (!item.fin || !out_valid_q || out_ready);
	assign pop     = take;

	// per-character update
	always_comb begin
		n_digit  = fx_digit_q;
		n_point  = fx_point_q;
		n_nz     = fx_nz_q;
		n_stop   = fx_stop_q;
		n_err    = fx_err_q;
		n_nzt    = nzt_q;
		n_pend   = pend_q;
		n_left   = left_q;
		n_rp     = rp_q;
		n_phase  = phase_q;
		n_mant   = mant_q;
		n_mag    = mag_q;
		n_neg    = neg_q;
		n_sci_ok = sci_ok_q;
		n_saw_e  = saw_e_q;

		if (item.proc) begin
			if (!fx_stop_q) begin
				case (item.cls)
					CL_POINT: begin
						if (fx_point_q && !fx_digit_q) begin
							n_err  = FE_DBLPT;
							n_stop = 1'b1;
						end else begin
							if (fx_point_q)
								n_stop = 1'b1;
							if (fx_nz_q) begin
								n_nzt  = nzt_q + pend_q;
								n_pend = '0;
							end
							n_point = 1'b1;
						end
					end
					CL_ZERO: begin
						if (fx_nz_q) begin
							if (fx_point_q) begin
								n_nzt = nzt_q + TALLY_W'(1);
							end else begin
								n_pend = pend_q + TALLY_W'(1);
								n_left = left_q + TALLY_W'(1);
							end
						end else if (fx_point_q) begin
							n_rp = rp_q - (TALLY_W+1)'(1);
						end
						n_digit = 1'b1;
					end
					CL_NZ: begin
						n_nzt  = nzt_q + pend_q + TALLY_W'(1);
						n_pend = '0;
						if (!fx_point_q)
							n_left = left_q + TALLY_W'(1);
						n_nz    = 1'b1;
						n_digit = 1'b1;
					end
					default: begin
						if (!fx_digit_q)
							n_err = FE_NONUM;
						n_stop = 1'b1;
					end
				endcase
			end

			if (item.cls == CL_EXP)
				n_saw_e = 1'b1;

			if (sci_ok_q) begin
				unique case (phase_q)
					SP_LEAD: begin
						if (is_dec) n_phase = SP_INT; else n_sci_ok = 1'b0;
					end
					SP_INT: begin
						if (item.cls == CL_POINT) n_phase = SP_FRAC;
						else if (item.cls == CL_EXP) n_phase = SP_ESIGN;
						else n_sci_ok = 1'b0;
					end
					SP_FRAC: begin
						if (is_dec) n_mant = mant_q + TALLY_W'(1);
						else if (item.cls == CL_EXP) n_phase = SP_ESIGN;
						else n_sci_ok = 1'b0;
					end
					SP_ESIGN: begin
						if (item.cls == CL_PLUS || item.cls == CL_MINUS) begin
							n_neg   = (item.cls == CL_MINUS);
							n_phase = SP_EDIG1;
						end else begin
							n_sci_ok = 1'b0;
						end
					end
					SP_EDIG1: begin
						if (is_dec) begin
							n_mag   = MAG_W'(item.dval);
							n_phase = SP_EDIGS;
						end else begin
							n_sci_ok = 1'b0;
						end
					end
					SP_EDIGS: begin
						if (is_dec)
							n_mag = (mag_acc > (MAG_W+3)'(EXP_SAT)) ? EXP_SAT
								: MAG_W'(mag_acc);
						else
							n_phase = SP_DONE;
					end
					default: ;
				endcase
			end
		end
	end

	// string-end result
	always_comb begin
		r_digits = '0;
		r_exp    = '0;
		r_status = ST_OK;
		if (item.empty) begin
			r_status = ST_EMPTY;
		end else if (item.over) begin
			r_status = ST_LONG;
		end else if (n_saw_e) begin
			if (!n_sci_ok || !(n_phase == SP_EDIGS || n_phase == SP_DONE)) begin
				r_status = ST_BADSCI;
			end else begin
				r_digits = n_mant + TALLY_W'(1);
				r_exp    = n_neg ? -$signed(EXP_W'(n_mag)) : $signed(EXP_W'(n_mag));
			end
		end else if (n_err == FE_DBLPT) begin
			r_status = ST_DBLPT;
		end else if (n_err == FE_NONUM || !n_digit) begin
			r_status = ST_NONUM;
		end else begin
			r_digits = n_nz ? n_nzt : TALLY_W'(-n_rp);
			if (n_left != '0)
				r_exp = $signed(EXP_W'(n_left)) - EXP_W'(1);
			else if (n_nz)
				r_exp = EXP_W'(n_rp);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_digit_q <= 1'b0;
			fx_point_q <= 1'b0;
			fx_nz_q    <= 1'b0;
			fx_stop_q  <= 1'b0;
			fx_err_q   <= FE_NONE;
			nzt_q      <= '0;
			pend_q     <= '0;
			left_q     <= '0;
			rp_q       <= -(TALLY_W+1)'(1);
			phase_q    <= SP_LEAD;
			mant_q     <= '0;
			mag_q      <= '0;
			neg_q      <= 1'b0;
			sci_ok_q   <= 1'b1;
			saw_e_q    <= 1'b0;
		end else if (take) begin
			if (item.fin) begin
				// start a fresh string
				fx_digit_q <= 1'b0;
				fx_point_q <= 1'b0;
				fx_nz_q    <= 1'b0;
				fx_stop_q  <= 1'b0;
				fx_err_q   <= FE_NONE;
				nzt_q      <= '0;
				pend_q     <= '0;
				left_q     <= '0;
				rp_q       <= -(TALLY_W+1)'(1);
				phase_q    <= SP_LEAD;
				mant_q     <= '0;
				mag_q      <= '0;
				neg_q      <= 1'b0;
				sci_ok_q   <= 1'b1;
				saw_e_q    <= 1'b0;
			end else begin
				fx_digit_q <= n_digit;
				fx_point_q <= n_point;
				fx_nz_q    <= n_nz;
				fx_stop_q  <= n_stop;
				fx_err_q   <= n_err;
				nzt_q      <= n_nzt;
				pend_q     <= n_pend;
				left_q     <= n_left;
				rp_q       <= n_rp;
				phase_q    <= n_phase;
				mant_q     <= n_mant;
				mag_q      <= n_mag;
				neg_q      <= n_neg;
				sci_ok_q   <= n_sci_ok;
				saw_e_q    <= n_saw_e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && item.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.fin) begin
			out_digits_q <= (16'(r_digits) > 16'(DIG_SAT)) ? DIG_SAT : DIG_W'(r_digits);
			out_exp_q    <= r_exp;
			out_status_q <= r_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_digits = out_digits_q;
	assign out_exp    = out_exp_q;
	assign out_status = out_status_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_OK |-> out_digits_q == '0 && out_exp_q == '0)
		else $error("error result carries nonzero fields");

	a_err_stops: assert property (@(posedge clk) disable iff (!arst_n)
		fx_err_q != FE_NONE |-> fx_stop_q)
		else $error("fixed error without stop");

	a_fin_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item.fin && out_valid_q && !out_ready |-> !pop)
		else $error("string end popped while result pending");

endmodule

// ===== rtl/core/numeric_string_sig_digit_parser_unit.sv =====
// Top level of the numeric string significant-digit parser.
// Instantiates nssdp_front, nssdp_queue and nssdp_back; depends on nssdp_pkg.
// Throughput: one character per cycle while the 4-entry queue has room.
// Reset: arst_n clears position, parser state, queue and output valid flag at once.
// No result for beats that do not end a string; one result per string otherwise.
module numeric_string_sig_digit_parser_unit import nssdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // is_last
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [6:0] sig_digits, [21:7] dec_exponent, [23:22] zero
	output logic [2:0]  m_tuser    // [2:0] status
);

	logic                    push;
	nssdp_item_t             push_item;
	logic                    q_full;
	logic                    pop;
	logic                    item_valid;
	nssdp_item_t             pop_item;
	logic [DIG_W-1:0]        digits;
	logic signed [EXP_W-1:0] dec_exp;
	status_t                 status;

	// classify each character and track position and length
	nssdp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_char   (s_tdata),
		.in_last   (s_tlast),
		.q_full    (q_full),
		.in_ready  (s_tready),
		.push      (push),
		.push_item (push_item)
	);

	// decouple the classifier from the parser so each can stall on its own
	nssdp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (q_full),
		.item_valid (item_valid),
		.pop_item   (pop_item)
	);

	// run both parsers and hold the result until the sink takes it
	nssdp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (pop_item),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_digits (digits),
		.out_exp    (dec_exp),
		.out_status (status)
	);

	// pack the result fields, lowest field in the lowest bits
	assign m_tdata = {2'b00, dec_exp, digits};
	assign m_tuser = status;

endmodule
